[hdl/slcan_ascii_frame_parser_defines.svh]
// Assertion helpers for the parser; slcan_decoder is the module that uses them.
// Each use expects clk and rst_n in scope.
`ifndef SLCAN_ASCII_FRAME_PARSER_DEFINES_SVH
`define SLCAN_ASCII_FRAME_PARSER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define SLCAN_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SLCAN_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/slcan_pkg.sv]
`timescale 1ns / 1ps

package slcan_pkg;

    localparam int unsigned MAX_DATA_BYTES = 8;

    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_STD     = 8'h74; // 't'
    localparam logic [7:0] CH_STD_RTR = 8'h72; // 'r'
    localparam logic [7:0] CH_EXT     = 8'h54; // 'T'
    localparam logic [7:0] CH_EXT_RTR = 8'h52; // 'R'

    localparam logic [3:0] STD_ID_DIGITS = 4'd3;
    localparam logic [3:0] EXT_ID_DIGITS = 4'd8;
    localparam logic [4:0] STAMP_DIGITS  = 5'd4;
    localparam logic [3:0] MAX_LEN       = 4'(MAX_DATA_BYTES);

    localparam int unsigned ID_W     = 29;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned STAMP_W  = 16;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned OUT_BITS = ID_W + 1 + 1 + LEN_W + PAYLOAD_W + STAMP_W + 1;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } slcan_char_t;

    typedef struct packed {
        logic                 malformed;
        logic [STAMP_W-1:0]   time_stamp;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     data_length;
        logic                 is_remote;
        logic                 is_extended;
        logic [ID_W-1:0]      can_id;
    } slcan_frame_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } slcan_hex_t;

    function automatic slcan_hex_t hex_decode(input logic [7:0] c);
        slcan_hex_t r;
        logic [7:0] d;
        r.ok = 1'b1;
        d    = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end
        else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end
        else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end
        else begin
            r.ok = 1'b0;
        end
        r.val = d[3:0];
        return r;
    endfunction

endpackage

[hdl/slcan_in_stage.sv]
`timescale 1ns / 1ps

module slcan_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // rx_char
    input  logic                 take,
    output slcan_pkg::slcan_char_t char_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;
    logic [7:0] ch_next;

    // The register is free when empty or when the decoder consumes it this cycle.
    assign s_axis_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        ch_next    = ch_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
            ch_next    = s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
    end

    assign char_q = '{valid: valid_reg, ch: ch_reg};

endmodule

[hdl/slcan_decoder.sv]
`timescale 1ns / 1ps
`include "slcan_ascii_frame_parser_defines.svh"

module slcan_decoder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  slcan_pkg::slcan_char_t char_q,
    output logic                   take,
    output logic                   out_valid,
    input  logic                   out_ready,
    output slcan_pkg::slcan_frame_t frame
);

    logic                              in_frame_reg, in_frame_next;
    logic                              ext_reg, ext_next;
    logic                              rtr_reg, rtr_next;
    logic [slcan_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [slcan_pkg::ID_W-1:0]        id_reg, id_next;
    logic [slcan_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [slcan_pkg::PAYLOAD_W-1:0]   data_reg, data_next;
    logic [slcan_pkg::STAMP_W-1:0]     stamp_reg, stamp_next;
    logic                              stamp_seen_reg, stamp_seen_next;
    logic                              err_reg, err_next;
    logic                              out_valid_reg, out_valid_next;
    slcan_pkg::slcan_frame_t           frame_reg, frame_next;

    logic [3:0]                        id_len;
    logic [slcan_pkg::POS_W-1:0]       data_end;
    logic [slcan_pkg::POS_W-1:0]       stamp_end;
    logic [slcan_pkg::POS_W-1:0]       off;
    logic [3:0]                        nib_idx;
    logic                              is_start;
    logic                              short_frame;
    logic [3:0]                        len_digit;
    slcan_pkg::slcan_hex_t             hex;

    // Drain the result register or find it empty before taking a character.
    assign take = char_q.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        id_len    = ext_reg ? slcan_pkg::EXT_ID_DIGITS : slcan_pkg::STD_ID_DIGITS;
        data_end  = 5'(id_len) + 5'd1 + (rtr_reg ? 5'd0 : {len_reg, 1'b0});
        stamp_end = data_end + slcan_pkg::STAMP_DIGITS;
        off       = pos_reg - 5'(id_len) - 5'd1;
        // High nibble of each byte arrives first.
        nib_idx   = {off[3:1], ~off[0]};
        is_start  = (char_q.ch == slcan_pkg::CH_STD) || (char_q.ch == slcan_pkg::CH_STD_RTR)
                 || (char_q.ch == slcan_pkg::CH_EXT) || (char_q.ch == slcan_pkg::CH_EXT_RTR);
        short_frame = (pos_reg < data_end) || ((pos_reg > data_end) && (pos_reg < stamp_end));
        hex       = slcan_pkg::hex_decode(char_q.ch);
        len_digit = char_q.ch[3:0];
    end

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        ext_next        = ext_reg;
        rtr_next        = rtr_reg;
        pos_next        = pos_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        data_next       = data_reg;
        stamp_next      = stamp_reg;
        stamp_seen_next = stamp_seen_reg;
        err_next        = err_reg;
        frame_next      = frame_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (take)
        begin
            if (!in_frame_reg)
            begin
                if (is_start)
                begin
                    in_frame_next   = 1'b1;
                    ext_next        = (char_q.ch == slcan_pkg::CH_EXT)
                                   || (char_q.ch == slcan_pkg::CH_EXT_RTR);
                    rtr_next        = (char_q.ch == slcan_pkg::CH_STD_RTR)
                                   || (char_q.ch == slcan_pkg::CH_EXT_RTR);
                    pos_next        = '0;
                    id_next         = '0;
                    len_next        = '0;
                    data_next       = '0;
                    stamp_next      = '0;
                    stamp_seen_next = 1'b0;
                    err_next        = 1'b0;
                end
            end
            else if (char_q.ch == slcan_pkg::CH_CR)
            begin
                in_frame_next          = 1'b0;
                out_valid_next         = 1'b1;
                frame_next.can_id      = id_reg;
                frame_next.is_extended = ext_reg;
                frame_next.is_remote   = rtr_reg;
                frame_next.data_length = len_reg;
                frame_next.payload     = data_reg;
                frame_next.time_stamp  = stamp_seen_reg ? stamp_reg : '0;
                frame_next.malformed   = err_reg || short_frame;
            end
            else if (pos_reg < stamp_end)
            begin
                pos_next = pos_reg + 5'd1;
                if (pos_reg < 5'(id_len))
                begin
                    if (!hex.ok)
                    begin
                        err_next = 1'b1;
                    end
                    id_next = {id_reg[slcan_pkg::ID_W-5:0], hex.val};
                end
                else if (pos_reg == 5'(id_len))
                begin
                    if (char_q.ch inside {[8'h30:8'h39]})
                    begin
                        if (len_digit > slcan_pkg::MAX_LEN)
                        begin
                            len_next = slcan_pkg::MAX_LEN;
                            err_next = 1'b1;
                        end
                        else
                        begin
                            len_next = len_digit;
                        end
                    end
                    else
                    begin
                        len_next = '0;
                        err_next = 1'b1;
                    end
                end
                else if (pos_reg < data_end)
                begin
                    if (!hex.ok)
                    begin
                        err_next = 1'b1;
                    end
                    for (int i = 0; i < slcan_pkg::PAYLOAD_W / 4; i++)
                    begin
                        if (nib_idx == 4'(i))
                        begin
                            data_next[i*4 +: 4] = data_reg[i*4 +: 4] | hex.val;
                        end
                    end
                end
                else
                begin
                    if (!hex.ok)
                    begin
                        err_next = 1'b1;
                    end
                    stamp_next = {stamp_reg[slcan_pkg::STAMP_W-5:0], hex.val};
                    if (pos_reg + 5'd1 == stamp_end)
                    begin
                        stamp_seen_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            ext_reg        <= 1'b0;
            rtr_reg        <= 1'b0;
            pos_reg        <= '0;
            id_reg         <= '0;
            len_reg        <= '0;
            data_reg       <= '0;
            stamp_reg      <= '0;
            stamp_seen_reg <= 1'b0;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            ext_reg        <= ext_next;
            rtr_reg        <= rtr_next;
            pos_reg        <= pos_next;
            id_reg         <= id_next;
            len_reg        <= len_next;
            data_reg       <= data_next;
            stamp_reg      <= stamp_next;
            stamp_seen_reg <= stamp_seen_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign out_valid = out_valid_reg;
    assign frame     = frame_reg;

    `SLCAN_ASSERT_ALWAYS(a_pos_in_layout, pos_reg <= 5'd29, "character position past layout")
    `SLCAN_ASSERT_ALWAYS(a_len_clamped, len_reg <= slcan_pkg::MAX_LEN, "length not clamped")
    `SLCAN_ASSERT_IMPLIES(a_std_id_narrow, in_frame_reg && !ext_reg, id_reg[slcan_pkg::ID_W-1:12] == '0, "standard identifier grew past 12 bits")
    `SLCAN_ASSERT_IMPLIES(a_result_from_frame, $rose(out_valid_reg), $past(in_frame_reg) && !in_frame_reg && ($past(char_q.ch) == slcan_pkg::CH_CR), "result without closing carriage return")
    `SLCAN_ASSERT_IMPLIES(a_no_take_when_blocked, out_valid_reg && !out_ready, !take, "character taken while result register blocked")

endmodule

[hdl/slcan_ascii_frame_parser.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Bits | Contents
// s_axis   | in  |   8  | one received character (rx_char)
// m_axis   | out | 120  | one decoded frame per carriage return inside a frame
//
// Takes one character per cycle unless a held result stalls s_axis; m_axis_tvalid rises
// once the closing carriage return has passed the input register, then the result register.
// Reset (rst_n low, asynchronous) empties both registers and leaves the parser idle.
// A result held on m_axis stalls s_axis only once the input register is also full.

module slcan_ascii_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] rx_char
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [28:0] can_id, [29] is_extended, [30] is_remote, [34:31] data_length,
    // [98:35] payload, [114:99] time_stamp, [115] malformed, [119:116] zero
    output logic [slcan_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    slcan_pkg::slcan_char_t  char_q;
    slcan_pkg::slcan_frame_t frame;
    logic                    take;

    slcan_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .char_q        (char_q)
    );

    slcan_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_q    (char_q),
        .take      (take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .frame     (frame)
    );

    assign m_axis_tdata = {(slcan_pkg::OUT_TDATA_W - slcan_pkg::OUT_BITS)'(0), frame};

endmodule
